[rtl/hpt_pkg.sv]
// shared types and constants of the heading pid turn controller
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int GAIN_W     = 20;
  localparam int LIMIT_W    = 17;
  localparam int TOL_W      = 15;
  localparam int CNT_W      = 6;
  localparam int TICK_W     = 16;
  localparam int SPD_W      = 7;
  localparam int HEAD_W     = 16;
  localparam int ERR_W      = 16;
  localparam int SUM_W      = 18;
  localparam int DER_W      = 17;
  localparam int P_W        = 20;
  localparam int WRAP_W     = 18;
  localparam int DRIVE_W    = 8;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam int FULL_CIRCLE = 36000;
  localparam int HALF_CIRCLE = 18000;
  localparam int SPEED_MAX   = 100;
  localparam int COUNT_MAX   = 63;
  localparam int SPEED_DFLT  = -1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_INTEG_LIMIT   = 3'd3,
    REG_TOLERANCE     = 3'd4,
    REG_SETTLE_TICKS  = 3'd5,
    REG_TIMEOUT_TICKS = 3'd6,
    REG_DEFAULT_SPEED = 3'd7
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRAP  = 9'b000000010,
    S_ERR   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_CLAMP = 9'b000100000,
    S_SPD   = 9'b001000000,
    S_ABS   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

[rtl/hpt_mac.sv]
// msb-first shift-and-add accumulator, one multiplier bit per cycle while enabled
`timescale 1ns / 1ps
module hpt_mac #(
  parameter int ACC_W = 40
) (
  input  logic                    clk_i,
  input  hpt_pkg::mac_ctrl_t      ctrl_i,
  input  logic signed [ACC_W-1:0] addend_i,
  output logic signed [ACC_W-1:0] acc_o
);
  import hpt_pkg::*;

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.en) begin
      acc_d = $signed({acc_q[ACC_W-2:0], 1'b0}) + addend_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

[rtl/heading_pid_turn.sv]
// heading pid turn controller top level
//
//  channel   dir  signals                                  payload
//  s_axis    in   s_axis_tvalid_i/tready_o/tdata_i/tuser_i  op, target, speed, heading
//  m_axis    out  m_axis_tvalid_o/tready_i/tdata_o/tuser_o  left, right drive, done
//  cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i             gains, limit, tolerance, ticks, speed
//
//  a start item or a tick with no move running goes from acceptance to the output
//  state, then s_axis_tready_o rises again; an active tick passes the wrap, error,
//  sum, multiply (gain bits), clamp, speed (speed bits), abs and output states.
//  one item is worked on at a time; the output register holds a result while
//  m_axis_tready_i is low and the next item may be accepted meanwhile.
//  rst_ni clears the control state and loads the default register values.
`timescale 1ns / 1ps
module heading_pid_turn #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // target_heading [15:0], speed_req [23:16], heading [39:24]
  input  logic [hpt_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // op
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // left_drive [7:0], right_drive [15:8]
  output logic [hpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // done_res
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hpt_pkg::*;

  localparam int TOT_W = GAIN_FRAC_BITS + 2;
  localparam int ACC_W = (GAIN_FRAC_BITS + 9 > 40) ? GAIN_FRAC_BITS + 9 : 40;
  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) << GAIN_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [WRAP_W-1:0] CIRC  = WRAP_W'(FULL_CIRCLE);
  localparam logic signed [WRAP_W-1:0] CIRC2 = WRAP_W'(2 * FULL_CIRCLE);
  localparam logic signed [WRAP_W-1:0] HALFC = WRAP_W'(HALF_CIRCLE);
  localparam logic signed [WRAP_W-1:0] HALF3 = WRAP_W'(3 * HALF_CIRCLE);

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [LIMIT_W-1:0] integ_limit_q;
  logic [TOL_W-1:0]   tolerance_q;
  logic [CNT_W-1:0]   settle_ticks_q;
  logic [TICK_W-1:0]  timeout_ticks_q;
  logic [SPD_W-1:0]   default_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= GAIN_W'(1864);
      integ_gain_q    <= GAIN_W'(37);
      deriv_gain_q    <= GAIN_W'(13981);
      integ_limit_q   <= LIMIT_W'(100000);
      tolerance_q     <= TOL_W'(200);
      settle_ticks_q  <= CNT_W'(20);
      timeout_ticks_q <= TICK_W'(250);
      default_speed_q <= SPD_W'(70);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_LIMIT:   integ_limit_q   <= cfg_data_i[LIMIT_W-1:0];
        REG_TOLERANCE:     tolerance_q     <= cfg_data_i[TOL_W-1:0];
        REG_SETTLE_TICKS:  settle_ticks_q  <= cfg_data_i[CNT_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[TICK_W-1:0];
        REG_DEFAULT_SPEED: default_speed_q <= cfg_data_i[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [HEAD_W-1:0]        in_target, in_heading;
  logic signed [DRIVE_W-1:0] in_speed;
  logic                     in_accept;
  assign in_target  = s_axis_tdata_i[15:0];
  assign in_speed   = $signed(s_axis_tdata_i[23:16]);
  assign in_heading = s_axis_tdata_i[39:24];
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;

  // move state
  state_e state_q, state_d;
  logic [HEAD_W-1:0]        goal_q, hd_q;
  logic [SPD_W-1:0]         speed_q;
  logic signed [SUM_W-1:0]  error_sum_q;
  logic signed [ERR_W-1:0]  prev_error_q, e_q;
  logic signed [DER_W-1:0]  deriv_q;
  logic [CNT_W-1:0]         settled_q;
  logic [TICK_W-1:0]        elapsed_q;
  logic                     active_q;
  logic [HEAD_W-1:0]        m_q;
  logic [GAIN_W-1:0]        gp_sr_q, gi_sr_q, gd_sr_q;
  logic [SPD_W-1:0]         spd_sr_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [TOT_W-1:0]  tot_q;
  logic [ACC_W-1:0]         mag_q;
  logic                     neg_q;
  logic signed [DRIVE_W-1:0] res_left_q;
  logic                     res_done_q;
  logic signed [DRIVE_W-1:0] out_left_q;
  logic                     out_done_q, out_valid_q;

  // start speed selection
  logic [SPD_W-1:0] dflt_sat, start_spd;
  always_comb begin
    dflt_sat = (default_speed_q > SPD_W'(SPEED_MAX)) ? SPD_W'(SPEED_MAX) : default_speed_q;
    if (in_speed == DRIVE_W'(SPEED_DFLT)) begin
      start_spd = dflt_sat;
    end else if (in_speed[DRIVE_W-1]) begin
      start_spd = '0;
    end else if (in_speed[SPD_W-1:0] > SPD_W'(SPEED_MAX)) begin
      start_spd = SPD_W'(SPEED_MAX);
    end else begin
      start_spd = in_speed[SPD_W-1:0];
    end
  end

  // heading difference folded into 0..35999 plus at most one circle, then mapped to a signed error
  logic signed [WRAP_W-1:0] diff, fold, m_x, e_x;
  always_comb begin
    diff = $signed({2'b00, goal_q}) - $signed({2'b00, hd_q});
    if (diff < -CIRC) begin
      fold = diff + CIRC2;
    end else if (diff < 0) begin
      fold = diff + CIRC;
    end else begin
      fold = diff;
    end
    m_x = $signed({2'b00, m_q});
    if (m_x > HALF3) begin
      e_x = m_x - CIRC2;
    end else if (m_x > HALFC) begin
      e_x = m_x - CIRC;
    end else begin
      e_x = m_x;
    end
  end

  // error sum clamp, derivative, settle tracking
  logic signed [SUM_W:0]   sum_raw, lim, sum_c;
  logic signed [DER_W-1:0] deriv_x;
  logic [TOL_W-1:0]        abs_e;
  logic [CNT_W-1:0]        settled_x;
  logic [TICK_W-1:0]       elapsed_x;
  logic                    finish;
  always_comb begin
    sum_raw = {error_sum_q[SUM_W-1], error_sum_q}
            + {{(SUM_W+1-ERR_W){e_q[ERR_W-1]}}, e_q};
    lim = $signed({2'b00, integ_limit_q});
    if (sum_raw > lim) begin
      sum_c = lim;
    end else if (sum_raw < -lim) begin
      sum_c = -lim;
    end else begin
      sum_c = sum_raw;
    end
    deriv_x = {e_q[ERR_W-1], e_q} - {prev_error_q[ERR_W-1], prev_error_q};
    abs_e = e_q[ERR_W-1] ? TOL_W'(-e_q) : TOL_W'(e_q);
    if (abs_e <= tolerance_q) begin
      settled_x = (settled_q < CNT_W'(COUNT_MAX)) ? settled_q + 1'b1 : settled_q;
    end else begin
      settled_x = '0;
    end
    elapsed_x = elapsed_q + 1'b1;
    finish = (settled_x > settle_ticks_q) || (elapsed_x >= timeout_ticks_q);
  end

  // serial multiplier feed
  logic signed [P_W-1:0]   p_sum;
  logic signed [ACC_W-1:0] addend, acc;
  mac_ctrl_t               mac_ctrl;
  always_comb begin
    p_sum = (gp_sr_q[GAIN_W-1] ? {{(P_W-ERR_W){e_q[ERR_W-1]}}, e_q} : P_W'(0))
          + (gi_sr_q[GAIN_W-1] ? {{(P_W-SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q}
                               : P_W'(0))
          + (gd_sr_q[GAIN_W-1] ? {{(P_W-DER_W){deriv_q[DER_W-1]}}, deriv_q} : P_W'(0));
    if (state_q == S_SPD) begin
      addend = spd_sr_q[SPD_W-1] ? {{(ACC_W-TOT_W){tot_q[TOT_W-1]}}, tot_q} : '0;
    end else begin
      addend = {{(ACC_W-P_W){p_sum[P_W-1]}}, p_sum};
    end
    mac_ctrl.clr = (state_q == S_SUM) || (state_q == S_CLAMP);
    mac_ctrl.en  = (state_q == S_MUL) || (state_q == S_SPD);
  end

  hpt_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .addend_i (addend),
    .acc_o    (acc)
  );

  // total clamp and rounding
  logic signed [TOT_W-1:0]   tot_x;
  logic [ACC_W-1:0]          q_full;
  logic [DRIVE_W-1:0]        q8;
  logic signed [DRIVE_W-1:0] left_x;
  always_comb begin
    if (acc > ONE) begin
      tot_x = ONE[TOT_W-1:0];
    end else if (acc < -ONE) begin
      tot_x = TOT_W'(-ONE);
    end else begin
      tot_x = acc[TOT_W-1:0];
    end
    q_full = (mag_q + HALF) >> GAIN_FRAC_BITS;
    q8 = q_full[DRIVE_W-1:0];
    left_x = neg_q ? $signed(DRIVE_W'(0) - q8) : $signed(q8);
  end

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (op_e'(s_axis_tuser_i) == OP_TICK && active_q) begin
            state_d = S_WRAP;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_WRAP:  state_d = S_ERR;
      S_ERR:   state_d = S_SUM;
      S_SUM:   state_d = S_MUL;
      S_MUL:   state_d = (step_q == STEP_W'(GAIN_W - 1)) ? S_CLAMP : S_MUL;
      S_CLAMP: state_d = S_SPD;
      S_SPD:   state_d = (step_q == STEP_W'(SPD_W - 1)) ? S_ABS : S_SPD;
      S_ABS:   state_d = S_OUT;
      S_OUT:   state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      goal_q       <= '0;
      speed_q      <= '0;
      error_sum_q  <= '0;
      prev_error_q <= '0;
      settled_q    <= '0;
      elapsed_q    <= '0;
      active_q     <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && op_e'(s_axis_tuser_i) == OP_START) begin
        goal_q       <= in_target;
        speed_q      <= start_spd;
        error_sum_q  <= '0;
        prev_error_q <= '0;
        settled_q    <= '0;
        elapsed_q    <= '0;
        active_q     <= 1'b1;
      end
      if (state_q == S_SUM) begin
        error_sum_q  <= sum_c[SUM_W-1:0];
        prev_error_q <= e_q;
        settled_q    <= settled_x;
        elapsed_q    <= elapsed_x;
        active_q     <= !finish;
      end
      if (state_q == S_MUL || state_q == S_SPD) begin
        step_q <= (state_d == state_q) ? step_q + 1'b1 : '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // rounded drive lands in the result register once rnd_pending_q, set by the abs stage, is high
  logic rnd_pending_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_pending_q <= 1'b0;
    end else begin
      rnd_pending_q <= (state_q == S_ABS);
    end
  end

  logic signed [DRIVE_W-1:0] res_left_fix;
  assign res_left_fix = rnd_pending_q ? left_x : res_left_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hd_q       <= in_heading;
      res_left_q <= '0;
      res_done_q <= (op_e'(s_axis_tuser_i) == OP_TICK);
    end
    if (state_q == S_WRAP) begin
      m_q <= fold[HEAD_W-1:0];
    end
    if (state_q == S_ERR) begin
      e_q <= e_x[ERR_W-1:0];
    end
    if (state_q == S_SUM) begin
      deriv_q    <= deriv_x;
      gp_sr_q    <= prop_gain_q;
      gi_sr_q    <= integ_gain_q;
      gd_sr_q    <= deriv_gain_q;
      res_done_q <= finish;
    end
    if (state_q == S_MUL) begin
      gp_sr_q <= {gp_sr_q[GAIN_W-2:0], 1'b0};
      gi_sr_q <= {gi_sr_q[GAIN_W-2:0], 1'b0};
      gd_sr_q <= {gd_sr_q[GAIN_W-2:0], 1'b0};
    end
    if (state_q == S_CLAMP) begin
      tot_q    <= tot_x;
      spd_sr_q <= speed_q;
    end
    if (state_q == S_SPD) begin
      spd_sr_q <= {spd_sr_q[SPD_W-2:0], 1'b0};
    end
    if (state_q == S_ABS) begin
      neg_q <= acc[ACC_W-1];
      mag_q <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
    if (out_load) begin
      out_left_q <= res_left_fix;
      out_done_q <= res_done_q;
    end
    if (state_q == S_ABS) begin
      res_left_q <= '0;
    end
    if (rnd_pending_q) begin
      res_left_q <= left_x;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {DRIVE_W'(0) - out_left_q, out_left_q};
  assign m_axis_tuser_o  = out_done_q;

endmodule

[rtl/hpt_checker.sv]
// port-level checks of the heading pid turn controller, bound to the top level
`timescale 1ns / 1ps
module hpt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [hpt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o
);
  import hpt_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // right drive is always the negated left drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:8] == 8'(8'd0 - m_axis_tdata_o[7:0]))
    else $error("right drive is not the negated left drive");

  // drive stays within plus or minus full speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[7:0]) <= $signed(8'(SPEED_MAX)) &&
      $signed(m_axis_tdata_o[7:0]) >= -$signed(8'(SPEED_MAX)))
    else $error("drive out of range");

  // one item at a time: ready drops after each accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

endmodule

bind heading_pid_turn hpt_checker u_hpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
